@@ design/cse_pkg.sv @@
// Shared types and constants of the cubic spline evaluator.
// Used by the knot memory, the divider, the evaluation sequencer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cse_pkg;

  localparam int XW        = 32;
  localparam int IDX_W     = 6;
  localparam int KC_W      = 7;
  localparam int ORD_W     = 3;
  localparam int CFG_IDX_W = 1;

  localparam int DIV_NW = 88;
  localparam int DIV_DW = 96;
  localparam int DIV_QW = 49;
  localparam int DIV_CW = 7;

  localparam logic [47:0] QCAP = 48'h8000_0000_0000;
  localparam logic signed [17:0] ONE_Q16 = 18'sh10000;

  localparam logic [ORD_W-1:0] ORD_VALUE = 3'd0;
  localparam logic [ORD_W-1:0] ORD_SLOPE = 3'd1;
  localparam logic [ORD_W-1:0] ORD_CURVE = 3'd2;
  localparam logic [ORD_W-1:0] ORD_JERK  = 3'd3;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KNOT_COUNT  = 1'b0,
    REG_DERIV_ORDER = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] a;
    logic signed [XW-1:0] b;
  } knot_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIV_NW-1:0] num;
    logic [DIV_DW-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DIV_QW-1:0] q;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ design/cubic_spline_evaluator_core.sv @@
// Top level of the cubic spline evaluator: command port, configuration registers,
// knot memory, evaluation sequencer and divider. Depends on cse_pkg and all cse_ modules.
//
// Usage:
//   Input items are taken on a rising edge with start high and busy low. An item
//   with operation 0 writes one knot entry (x, y, a, b) in that cycle and gives no
//   result; busy stays low, so writes can follow back to back. An item with
//   operation 1 evaluates sample_x; busy rises and stays high until the result.
//   Each result is shown for one cycle with result_valid high; the receiver cannot
//   stall it, and busy falls in that same cycle.
//   Evaluate steps: the table scan reads one entry a cycle, up to the last used
//   knot, then each iterative division runs to completion. Orders 0 to 3 run two
//   divisions when the sample lies strictly inside its segment, one at or beyond
//   the segment ends. Order 4 and above, or a segment that is not ascending: none.
//   Configuration: cfg_index 0 is knot_count, 1 is derivative_order; cfg_ready is
//   always high. Write registers only while busy is low.
//   Reset sets knot_count to 2 and derivative_order to 0; table contents are
//   undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module cubic_spline_evaluator_core #(
  parameter int MAX_KNOTS   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 operation,
  input  logic [cse_pkg::IDX_W-1:0]            knot_index,
  input  logic signed [cse_pkg::XW-1:0]        knot_x,
  input  logic signed [cse_pkg::XW-1:0]        knot_y,
  input  logic signed [cse_pkg::XW-1:0]        knot_a,
  input  logic signed [cse_pkg::XW-1:0]        knot_b,
  input  logic signed [cse_pkg::XW-1:0]        sample_x,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cse_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cse_pkg::KC_W-1:0]             cfg_data,
  output logic                                 result_valid,
  output logic signed [VALUE_WIDTH-1:0]        result_value,
  output logic                                 saturated
);
  import cse_pkg::*;

  localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;

  logic [KC_W-1:0]  knot_count;
  logic [ORD_W-1:0] derivative_order;
  logic             accept;
  logic             wr_en;
  logic             go;
  logic [AW-1:0]    last;
  logic [AW-1:0]    raddr;
  knot_t            wdata;
  knot_t            rdata;
  div_req_t         dreq;
  div_rsp_t         drsp;
  logic [VALUE_WIDTH-1:0] out_value;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign wr_en     = accept && (operation == OP_WRITE) && (32'(knot_index) < MAX_KNOTS);
  assign go        = accept && (operation == OP_EVAL);
  assign wdata     = '{x: knot_x, y: knot_y, a: knot_a, b: knot_b};
  assign result_value = signed'(out_value);

  always_comb begin
    if (knot_count < KC_W'(2)) begin
      last = AW'(1);
    end else if (32'(knot_count) > 32'(MAX_KNOTS)) begin
      last = AW'(MAX_KNOTS - 1);
    end else begin
      last = AW'(knot_count - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count       <= KC_W'(2);
      derivative_order <= ORD_VALUE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KNOT_COUNT:  knot_count       <= cfg_data;
        REG_DERIV_ORDER: derivative_order <= cfg_data[ORD_W-1:0];
        default: ;
      endcase
    end
  end

  cse_knot_mem #(
    .DEPTH (MAX_KNOTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(knot_index)),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  cse_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  cse_eval #(
    .AW          (AW),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_eval (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .sample_x  (sample_x),
    .last      (last),
    .order     (derivative_order),
    .busy      (busy),
    .raddr     (raddr),
    .rdata     (rdata),
    .dreq      (dreq),
    .drsp      (drsp),
    .out_valid (result_valid),
    .out_value (out_value),
    .out_sat   (saturated)
  );

endmodule

`default_nettype wire

@@ design/cse_knot_mem.sv @@
// Knot table: one entry of x, y, a and b per knot, one write and one read port.
// Read data is registered and appears in the cycle after the read address. Depends on cse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cse_knot_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  cse_pkg::knot_t    wdata,
  input  logic [AW-1:0]     raddr,
  output cse_pkg::knot_t    rdata
);
  import cse_pkg::*;

  knot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/cse_div.sv @@
// Restoring divider, one quotient bit per cycle, signed numerator, positive divisor.
// Floor rounding, quotient magnitude capped. Depends on cse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cse_div (
  input  logic                clk,
  input  logic                rst,
  input  cse_pkg::div_req_t   req,
  output cse_pkg::div_rsp_t   rsp
);
  import cse_pkg::*;

  logic              running;
  logic              done;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_NW-1:0] nsh;
  logic [DIV_DW:0]   rem;
  logic [DIV_DW-1:0] den;
  logic [47:0]       q;
  logic              neg;

  logic [DIV_DW:0]   rem_sh;
  logic              ge;
  logic [DIV_DW:0]   rem_next;
  logic [48:0]       qt;
  logic [47:0]       q_next;
  logic [47:0]       qf;

  always_comb begin
    rem_sh   = {rem[DIV_DW-1:0], nsh[DIV_NW-1]};
    ge       = (rem_sh >= {1'b0, den});
    rem_next = ge ? (rem_sh - {1'b0, den}) : rem_sh;
    qt       = {q, ge};
    q_next   = (qt > {1'b0, QCAP}) ? QCAP : qt[47:0];
    qf       = q + 48'(neg && (rem != '0) && (q < QCAP));
  end

  assign rsp.done = done;
  assign rsp.q    = neg ? -signed'({1'b0, qf}) : signed'({1'b0, qf});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= DIV_CW'(DIV_NW);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.num[DIV_NW-1];
      nsh <= req.num[DIV_NW-1] ? DIV_NW'(-req.num) : DIV_NW'(req.num);
      den <= req.den;
      rem <= '0;
      q   <= '0;
    end else if (running) begin
      nsh <= {nsh[DIV_NW-2:0], 1'b0};
      rem <= rem_next;
      q   <= q_next;
    end
  end

endmodule

`default_nettype wire

@@ design/cse_eval.sv @@
// Evaluation sequencer: scans the knot table, then steps the segment arithmetic
// through one registered multiplier and the shared divider. Depends on cse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cse_eval #(
  parameter int AW          = 6,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic signed [cse_pkg::XW-1:0]   sample_x,
  input  logic [AW-1:0]                   last,
  input  logic [cse_pkg::ORD_W-1:0]       order,
  output logic                            busy,
  output logic [AW-1:0]                   raddr,
  input  cse_pkg::knot_t                  rdata,
  output cse_pkg::div_req_t               dreq,
  input  cse_pkg::div_rsp_t               drsp,
  output logic                            out_valid,
  output logic [VALUE_WIDTH-1:0]          out_value,
  output logic                            out_sat
);
  import cse_pkg::*;

  localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_MIN = -OUT_MAX - 64'sd1;
  localparam logic signed [48:0] S32_MAX = 49'sd2147483647;
  localparam logic signed [48:0] S32_MIN = -49'sd2147483648;

  typedef enum logic [4:0] {
    S_IDLE, S_RD0, S_SCAN, S_XMAX, S_PREP, S_CHK, S_TDIV,
    S_MUA, S_MTB, S_MTU, S_BR, S_N1, S_N2, S_SDIV,
    S_Y1, S_Y2, S_Y3, S_Y4, S_E1, S_E2, S_E3, S_E4,
    S_K1, S_K2, S_C1, S_C2, S_C3, S_QDIV, S_CLIP
  } state_t;

  state_t state;

  logic [AW-1:0]           idx;
  logic [ORD_W-1:0]        ord;
  logic signed [XW-1:0]    cur, x0, y0, x1, y1, a, b, xmin, xmax, s32;
  logic signed [32:0]      dx, dc;
  logic signed [17:0]      t, u;
  logic signed [33:0]      m, w;
  logic signed [71:0]      acc;
  logic signed [63:0]      res;
  logic signed [48:0]      slope;
  logic [63:0]             d2;
  logic                    flag, sf;
  logic signed [67:0]      prod;

  logic signed [33:0]      ma, mb;
  logic signed [32:0]      amb, bma, dy, dmin, dmax;
  logic signed [33:0]      bm2a;
  logic signed [35:0]      amb6;
  logic signed [71:0]      p72, psh;
  logic                    stop;
  logic signed [63:0]      clipped;
  logic                    clip_hit;

  assign busy = (state != S_IDLE);

  always_comb begin
    amb  = 33'(a) - 33'(b);
    bma  = 33'(b) - 33'(a);
    dy   = 33'(y1) - 33'(y0);
    dmin = 33'(cur) - 33'(xmin);
    dmax = 33'(cur) - 33'(xmax);
    bm2a = 34'(b) - (34'(a) <<< 1);
    amb6 = (36'(amb) <<< 1) + (36'(amb) <<< 2);
    p72  = 72'(prod);
    psh  = p72 >>> 16;
    stop = (rdata.x >= cur) || (idx == last);
    if (res > OUT_MAX) begin
      clipped  = OUT_MAX;
      clip_hit = 1'b1;
    end else if (res < OUT_MIN) begin
      clipped  = OUT_MIN;
      clip_hit = 1'b1;
    end else begin
      clipped  = res;
      clip_hit = 1'b0;
    end
  end

  always_comb begin
    case (state)
      S_RD0:   raddr = AW'(1);
      S_SCAN:  raddr = stop ? last : AW'(idx + 1'b1);
      default: raddr = '0;
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_MUA: begin ma = 34'(u); mb = 34'(a); end
      S_MTB: begin ma = 34'(t); mb = 34'(b); end
      S_MTU: begin ma = 34'(t); mb = 34'(u); end
      S_BR: begin
        if (ord == ORD_CURVE) begin
          ma = 34'(amb); mb = 34'(t);
        end else if (ord == ORD_JERK) begin
          ma = 34'(dx); mb = 34'(dx);
        end else begin
          ma = 34'(u - t); mb = m;
        end
      end
      S_N1:  begin ma = w; mb = 34'(bma); end
      S_Y1:  begin ma = 34'(u); mb = 34'(y0); end
      S_Y2:  begin ma = 34'(t); mb = 34'(y1); end
      S_Y3:  begin ma = w; mb = m; end
      S_E1:  begin ma = 34'(s32); mb = 34'(dmin); end
      S_E3:  begin ma = 34'(s32); mb = 34'(dmax); end
      S_K1:  begin ma = 34'(dx); mb = 34'(dx); end
      S_C1:  begin ma = signed'({2'b00, prod[31:0]}); mb = 34'(dx); end
      S_C2:  begin ma = signed'({2'b00, d2[63:32]}); mb = 34'(dx); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      out_valid  <= 1'b0;
      dreq.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            cur   <= sample_x;
            ord   <= order;
            flag  <= 1'b0;
            state <= S_RD0;
          end
        end
        S_RD0: begin
          x0    <= rdata.x;
          y0    <= rdata.y;
          xmin  <= rdata.x;
          idx   <= AW'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (stop) begin
            x1    <= rdata.x;
            y1    <= rdata.y;
            a     <= rdata.a;
            b     <= rdata.b;
            state <= S_XMAX;
          end else begin
            x0  <= rdata.x;
            y0  <= rdata.y;
            idx <= AW'(idx + 1'b1);
          end
        end
        S_XMAX: begin
          xmax  <= rdata.x;
          state <= S_PREP;
        end
        S_PREP: begin
          dx    <= 33'(x1) - 33'(x0);
          dc    <= 33'(cur) - 33'(x0);
          state <= S_CHK;
        end
        S_CHK: begin
          if (ord > ORD_JERK) begin
            res   <= '0;
            state <= S_CLIP;
          end else if (dx <= 33'sd0) begin
            res   <= '0;
            flag  <= 1'b1;
            state <= S_CLIP;
          end else if (dc <= 33'sd0) begin
            t     <= '0;
            u     <= ONE_Q16;
            state <= S_MUA;
          end else if (dc >= dx) begin
            t     <= ONE_Q16;
            u     <= '0;
            state <= S_MUA;
          end else begin
            dreq.start <= 1'b1;
            dreq.num   <= 88'(dc) <<< 16;
            dreq.den   <= 96'(dx[31:0]);
            state      <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (drsp.done) begin
            t     <= 18'(drsp.q);
            u     <= ONE_Q16 - 18'(drsp.q);
            state <= S_MUA;
          end
        end
        S_MUA: state <= S_MTB;
        S_MTB: begin
          acc   <= p72;
          state <= S_MTU;
        end
        S_MTU: begin
          m     <= 34'((acc + p72) >>> 16);
          state <= S_BR;
        end
        S_BR: begin
          w <= 34'(prod);
          if (ord == ORD_CURVE) begin
            state <= S_K1;
          end else if (ord == ORD_JERK) begin
            state <= S_C1;
          end else begin
            state <= S_N1;
          end
        end
        S_N1: begin
          acc   <= p72;
          state <= S_N2;
        end
        S_N2: begin
          dreq.start <= 1'b1;
          dreq.num   <= 88'(acc + psh + (72'(dy) <<< 16));
          dreq.den   <= 96'(dx[31:0]);
          state      <= S_SDIV;
        end
        S_SDIV: begin
          if (drsp.done) begin
            slope <= drsp.q;
            if (ord == ORD_SLOPE) begin
              res   <= 64'(drsp.q);
              state <= S_CLIP;
            end else begin
              state <= S_Y1;
            end
          end
        end
        S_Y1: state <= S_Y2;
        S_Y2: begin
          acc   <= p72;
          state <= S_Y3;
        end
        S_Y3: begin
          acc   <= acc + p72;
          state <= S_Y4;
        end
        S_Y4: begin
          res <= 64'((acc + psh) >>> 16);
          if (slope > S32_MAX) begin
            s32 <= 32'h7FFF_FFFF;
            sf  <= 1'b1;
          end else if (slope < S32_MIN) begin
            s32 <= 32'h8000_0000;
            sf  <= 1'b1;
          end else begin
            s32 <= 32'(slope);
            sf  <= 1'b0;
          end
          state <= S_E1;
        end
        S_E1: state <= dmin[32] ? S_E2 : S_E3;
        S_E2: begin
          res   <= res + 64'(psh);
          flag  <= flag | sf;
          state <= S_E3;
        end
        S_E3: state <= (dmax > 33'sd0) ? S_E4 : S_CLIP;
        S_E4: begin
          res   <= res + 64'(psh);
          flag  <= flag | sf;
          state <= S_CLIP;
        end
        S_K1: begin
          acc   <= (72'(bm2a) <<< 16) + p72 + (p72 <<< 1);
          state <= S_K2;
        end
        S_K2: begin
          dreq.start <= 1'b1;
          dreq.num   <= 88'(acc) <<< 17;
          dreq.den   <= 96'(prod[63:0]);
          state      <= S_QDIV;
        end
        S_C1: begin
          d2    <= prod[63:0];
          state <= S_C2;
        end
        S_C2: begin
          acc   <= p72;
          state <= S_C3;
        end
        S_C3: begin
          dreq.start <= 1'b1;
          dreq.num   <= 88'(amb6) <<< 48;
          dreq.den   <= (96'(prod[63:0]) << 32) + 96'(acc[63:0]);
          state      <= S_QDIV;
        end
        S_QDIV: begin
          if (drsp.done) begin
            res   <= 64'(drsp.q);
            state <= S_CLIP;
          end
        end
        S_CLIP: begin
          out_valid <= 1'b1;
          out_value <= VALUE_WIDTH'(clipped);
          out_sat   <= flag | clip_hit;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench of cubic_spline_evaluator_core: knot table writes,
// evaluations at every derivative order, and knot count and order settings.
// Depends on cse_pkg and the design sources; the expected values are predicted in place.
`timescale 1ns / 1ps

import cse_pkg::*;

typedef struct {
  logic signed [31:0] value;
  logic               sat;
} spline_result_t;

class spline_scoreboard;
  longint         tab_x[64], tab_y[64], tab_a[64], tab_b[64];
  int unsigned    count_reg = 2;
  int unsigned    order_reg = 0;
  spline_result_t pending[$];
  int             errors = 0;
  int             evals = 0;
  int             sat_seen = 0;

  function int unsigned used_knots();
    if (count_reg < 2) return 2;
    if (count_reg > 64) return 64;
    return count_reg;
  endfunction

  function void set_reg(cfg_reg_t idx, logic [KC_W-1:0] data);
    if (idx == REG_KNOT_COUNT) count_reg = data;
    else order_reg = data & 7;
  endfunction

  // floor(num * 2^sh / den), magnitude capped
  function longint scaled_quotient(longint num, int sh, logic [127:0] den);
    logic [191:0] n, q, r;
    logic [63:0]  mag;
    longint       qq;
    bit           neg;
    neg = num < 0;
    mag = neg ? 64'(-num) : 64'(num);
    n = {128'b0, mag} << sh;
    q = n / {64'b0, den};
    r = n % {64'b0, den};
    if (q >= 192'(QCAP)) begin
      qq = longint'(QCAP);
    end else begin
      qq = longint'(q[63:0]);
      if (neg && r != 0) qq = qq + 1;
    end
    return neg ? -qq : qq;
  endfunction

  function longint clip(longint v, longint lo, longint hi, ref bit f);
    if (v > hi) begin f = 1; return hi; end
    if (v < lo) begin f = 1; return lo; end
    return v;
  endfunction

  function spline_result_t evaluate(longint cur);
    spline_result_t rv;
    int unsigned n, s;
    longint x0, x1, y0, y1, a, b, dx, t, u, m, w, res, num, slope, y, s32, k;
    logic [127:0] d;
    bit flag, sf;
    n = used_knots();
    s = 1;
    flag = 0;
    sf = 0;
    res = 0;
    while (s < n - 1 && tab_x[s] < cur) s++;
    x0 = tab_x[s-1]; x1 = tab_x[s];
    y0 = tab_y[s-1]; y1 = tab_y[s];
    a = tab_a[s]; b = tab_b[s];
    dx = x1 - x0;
    if (order_reg >= 4) begin
      res = 0;
    end else if (dx <= 0) begin
      res = 0;
      flag = 1;
    end else begin
      d = 128'(dx);
      if (cur - x0 <= 0) t = 0;
      else if (cur - x0 >= dx) t = 65536;
      else t = scaled_quotient(cur - x0, 16, d);
      u = 65536 - t;
      m = (u * a + t * b) >>> 16;
      w = t * u;
      if (order_reg <= 1) begin
        num = (y1 - y0) * 65536 + (u - t) * m + ((w * (b - a)) >>> 16);
        slope = scaled_quotient(num, 0, d);
        if (order_reg == 1) begin
          res = slope;
        end else begin
          y = (u * y0 + t * y1 + ((w * m) >>> 16)) >>> 16;
          s32 = clip(slope, -64'sd2147483648, 64'sd2147483647, sf);
          if (cur < tab_x[0]) begin
            y = y + ((s32 * (cur - tab_x[0])) >>> 16);
            flag = flag | sf;
          end
          if (cur > tab_x[n-1]) begin
            y = y + ((s32 * (cur - tab_x[n-1])) >>> 16);
            flag = flag | sf;
          end
          res = y;
        end
      end else if (order_reg == 2) begin
        k = (b - 2 * a) * 65536 + 3 * (a - b) * t;
        res = scaled_quotient(2 * k, 16, d * d);
      end else begin
        res = scaled_quotient(6 * (a - b), 48, d * d * d);
      end
      res = clip(res, -64'sd2147483648, 64'sd2147483647, flag);
    end
    rv.value = res[31:0];
    rv.sat = flag;
    return rv;
  endfunction

  function void note_item(op_t op, logic [5:0] idx, logic signed [31:0] kx,
                          logic signed [31:0] ky, logic signed [31:0] ka,
                          logic signed [31:0] kb, logic signed [31:0] sx);
    if (op == OP_WRITE) begin
      tab_x[idx] = kx; tab_y[idx] = ky; tab_a[idx] = ka; tab_b[idx] = kb;
    end else begin
      pending.push_back(evaluate(longint'(sx)));
      evals++;
    end
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, want %h", what, got, want);
    errors++;
  endtask

  task check_result(logic signed [31:0] value, logic sat);
    spline_result_t e;
    if (pending.size() == 0) begin
      report("unexpected result", value, 0);
      return;
    end
    e = pending.pop_front();
    if (sat) sat_seen++;
    if (value !== e.value) report("result_value", value, e.value);
    if (sat !== e.sat) report("saturated", 32'(sat), 32'(e.sat));
  endtask
endclass

module tb;
  logic              clk = 0;
  logic              rst = 1;
  logic              start = 0;
  logic              busy;
  op_t               operation = OP_WRITE;
  logic [IDX_W-1:0]  knot_index = 0;
  logic signed [31:0] knot_x = 0, knot_y = 0, knot_a = 0, knot_b = 0, sample_x = 0;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  cfg_reg_t          cfg_index = REG_KNOT_COUNT;
  logic [KC_W-1:0]   cfg_data = 0;
  logic              result_valid;
  logic signed [31:0] result_value;
  logic              saturated;

  spline_scoreboard sb = new();
  int  progress = 0;
  int  items = 0;
  bit  no_gaps = 0;

  cubic_spline_evaluator_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .knot_index(knot_index), .knot_x(knot_x), .knot_y(knot_y), .knot_a(knot_a),
    .knot_b(knot_b), .sample_x(sample_x), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .result_value(result_value), .saturated(saturated)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      progress++;
      sb.check_result(result_value, saturated);
    end
  end

  int last_progress = 0;
  int stall = 0;
  always @(posedge clk) begin
    if (progress != last_progress) begin
      last_progress = progress;
      stall = 0;
    end else begin
      stall++;
      if (stall >= 6000) begin
        $display("watchdog: no progress for %0d cycles", stall);
        $display("status: fail");
        $finish;
      end
    end
  end

  function int unsigned gap_len();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task idle_gap();
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      start = 0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task send_item(op_t op, logic [5:0] idx, logic signed [31:0] kx,
                 logic signed [31:0] ky, logic signed [31:0] ka,
                 logic signed [31:0] kb, logic signed [31:0] sx);
    @(negedge clk);
    start = 1;
    operation = op;
    knot_index = idx;
    knot_x = kx; knot_y = ky; knot_a = ka; knot_b = kb;
    sample_x = sx;
    do @(posedge clk); while (busy);
    progress++;
    items++;
    sb.note_item(op, idx, kx, ky, ka, kb, sx);
    idle_gap();
  endtask

  task write_knot(logic [5:0] idx, logic signed [31:0] kx, logic signed [31:0] ky,
                  logic signed [31:0] ka, logic signed [31:0] kb);
    send_item(OP_WRITE, idx, kx, ky, ka, kb, $urandom);
  endtask

  task eval_at(logic signed [31:0] sx);
    send_item(OP_EVAL, 6'($urandom), $urandom, $urandom, $urandom, $urandom, sx);
  endtask

  task drain();
    @(negedge clk);
    start = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(cfg_reg_t idx, logic [KC_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    progress++;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function logic signed [31:0] coef_value();
    if ($urandom_range(0, 1)) return $urandom;
    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  task fill_table(int unsigned n);
    longint xs[64];
    longint total, step_max, base;
    int unsigned i;
    step_max = ($urandom_range(0, 2) == 0) ? 64'd4294967295 / n : 64'd200000;
    total = 0;
    xs[0] = 0;
    for (i = 1; i < n; i++) begin
      total = total + longint'($urandom_range(1, 32'(step_max)));
      if ($urandom_range(0, 19) == 0) total = total - longint'($urandom_range(0, 3));
      xs[i] = total;
    end
    base = -64'sd2147483648 + longint'($urandom_range(0, 32'(64'd4294967295 - total)));
    for (i = 0; i < n; i++)
      write_knot(6'(i), 32'(xs[i] + base), coef_value(), coef_value(), coef_value());
  endtask

  function logic signed [31:0] pick_sample(int unsigned n);
    int unsigned r, i;
    longint lo, hi;
    r = $urandom_range(0, 9);
    i = $urandom_range(0, n - 1);
    case (r)
      0: return $urandom;
      1: return ($urandom_range(0, 1)) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      2: return 32'(sb.tab_x[i]);
      3: return 32'(sb.tab_x[i] + (($urandom_range(0, 1)) ? 1 : -1));
      default: begin
        if (i == 0) i = 1;
        lo = sb.tab_x[i-1];
        hi = sb.tab_x[i];
        if (hi <= lo) return 32'(lo);
        return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
      end
    endcase
  endfunction

  initial begin
    int unsigned n, k, o, r;
    logic signed [31:0] edges[3];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // two-knot table at reset count, every order at the edges and middle
    write_knot(0, 0, 0, 32'sh0001_0000, -32'sh0001_0000);
    write_knot(1, 32'sh0001_0000, 32'sh0001_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    edges[0] = 32'sh8000_0000;
    edges[1] = 32'sh0000_8000;
    edges[2] = 32'sh7fff_ffff;
    for (o = 0; o < 5; o++) begin
      drain();
      write_reg(REG_DERIV_ORDER, KC_W'(o));
      for (k = 0; k < 3; k++) eval_at(edges[k]);
    end
    drain();
    write_reg(REG_DERIV_ORDER, KC_W'(ORD_VALUE));
    write_knot(1, 0, 32'sh7fff_ffff, 0, 0);
    eval_at(32'sh0000_1000);
    write_knot(1, 1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    eval_at(32'sh7fff_ffff);
    eval_at(32'sh0000_0000);

    while (items < 1650) begin
      drain();
      r = $urandom_range(0, 9);
      case (r)
        0: n = 2;
        1: n = 64;
        2: n = $urandom_range(0, 1);
        3: n = $urandom_range(65, 127);
        4: n = $urandom_range(2, 64);
        default: n = $urandom_range(2, 10);
      endcase
      write_reg(REG_KNOT_COUNT, KC_W'(n));
      write_reg(REG_DERIV_ORDER, {4'($urandom_range(0, 15)), 3'($urandom_range(0, 7))});
      no_gaps = ($urandom_range(0, 3) == 0);
      fill_table(sb.used_knots());
      k = $urandom_range(4, 12);
      repeat (k) eval_at(pick_sample(sb.used_knots()));
    end
    drain();
    repeat (300) @(posedge clk);
    $display("ran %0d items, %0d evaluations, %0d flagged saturated",
             items, sb.evals, sb.sat_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/cse_pkg.sv
design/cse_knot_mem.sv
design/cse_div.sv
design/cse_eval.sv
design/cubic_spline_evaluator_core.sv
tb/sv/tb.sv
